// ===== design/fat12_cluster_chain_allocator_assert.svh =====
// assertion macros for the fat12 cluster chain allocator
// no dependencies; taken in by the modules that check their own logic
`ifndef FAT12_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fca assertion failed");
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fca assertion failed");
`else
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/fca_pkg.sv =====
// shared types and constants for the fat12 cluster chain allocator
// no dependencies
package fca_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int ENTRY_W = 12;
  localparam int KIND_W = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2880;
  localparam logic [LIMIT_W-1:0] FIRST_DATA_ENTRY = 13'd2;
  localparam logic [ENTRY_W-1:0] END_MARK = 12'hFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 12'h000;

  localparam logic [KIND_W-1:0] KIND_START = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_CHAIN = 2'd2;

  localparam logic REG_SCAN_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [ENTRY_W-1:0]  cluster;
    logic [ENTRY_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== design/fat12_cluster_chain_allocator.sv =====
// top level of the fat12 cluster chain allocator: apb register, output register
// depends on fca_pkg, fca_table and fca_ctrl
//
//   channel  signals                                      direction
//   in       in_valid in_ready kind entry_index entry_value  request in
//   out      out_valid out_ready cluster read_value status  result out
//   apb      psel penable pwrite paddr pwdata prdata pready scan_limit access
//
// start and next requests scan one entry per cycle through the shared counter and
// compare, from entry 2 up to but not including min(scan_limit, TABLE_ENTRIES)
// end, write and unused requests go straight to ST_FINISH; read requests pass ST_READ first
// after reset a clearing pass zeroes every table entry; in_ready stays low
// a result stalled on out_ready lets one more request in; its result waits in ST_FINISH
module fat12_cluster_chain_allocator import fca_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ENTRY_W-1:0]  entry_index,
  input  logic [ENTRY_W-1:0]  entry_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENTRY_W-1:0]  cluster,
  output logic [ENTRY_W-1:0]  read_value,
  output logic [STATUS_W-1:0] status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [LIMIT_W-1:0] scan_limit;
  res_t               res;
  logic               res_take;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCAN_LIMIT) ? PDATA_W'(scan_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SCAN_LIMIT) begin
      scan_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  fca_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fca_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .scan_limit  (scan_limit),
    .res         (res),
    .res_take    (res_take),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      cluster    <= res.cluster;
      read_value <= res.read_value;
      status     <= res.status;
    end
  end

endmodule

// ===== design/fca_table.sv =====
// fat table storage: one write port, one read port with registered data
// depends on fca_pkg
module fca_table import fca_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fca_ctrl.sv =====
// sequencer with the shared scan counter and compare for free-entry search
// depends on fca_pkg and fat12_cluster_chain_allocator_assert.svh
`include "fat12_cluster_chain_allocator_assert.svh"
module fca_ctrl import fca_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ENTRY_W-1:0]  entry_index,
  input  logic [ENTRY_W-1:0]  entry_value,
  input  logic [LIMIT_W-1:0]  scan_limit,
  output res_t                res,
  input  logic                res_take,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [ENTRY_W-1:0]  mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [ENTRY_W-1:0]  mem_rdata
);

  localparam logic [LIMIT_W-1:0] TABLE_LIMIT = LIMIT_W'(TABLE_ENTRIES);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(TABLE_ENTRIES - 1);

  state_t              state, state_next;
  logic [AW-1:0]       clr;
  logic [LIMIT_W-1:0]  ptr;
  logic                chk_valid;
  logic [AW-1:0]       chk_idx;
  logic                skip_q;
  logic [AW-1:0]       cur;
  logic                chain_open;
  logic [ENTRY_W-1:0]  res_cluster;
  logic [ENTRY_W-1:0]  res_read;
  logic [STATUS_W-1:0] res_status;

  logic [LIMIT_W-1:0]  lim;
  logic                accept;
  logic                found;
  logic                exhausted;
  logic                chk_live;

  assign lim = (scan_limit > TABLE_LIMIT) ? TABLE_LIMIT : scan_limit;
  assign accept = in_valid && in_ready;
  assign found = chk_valid && (mem_rdata == ENTRY_FREE) && !(skip_q && (chk_idx == cur));
  assign exhausted = ptr >= lim;
  assign chk_live = (state == ST_SCAN) && chk_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr == CLEAR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_START: state_next = ST_SCAN;
            KIND_NEXT:  state_next = chain_open ? ST_SCAN : ST_FINISH;
            KIND_READ:  state_next = ST_READ;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (found || exhausted) state_next = ST_FINISH;
      end
      ST_READ:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_take) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = entry_index[AW-1:0];
    mem_wdata = entry_value;
    mem_raddr = entry_index[AW-1:0];
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = ENTRY_FREE;
      end
      ST_IDLE: begin
        if (accept && kind == KIND_WRITE) begin
          mem_we = 1'b1;
        end else if (accept && kind == KIND_END && chain_open) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = END_MARK;
        end
      end
      ST_SCAN: begin
        mem_raddr = ptr[AW-1:0];
        // link the current entry to the new cluster
        if (found && skip_q) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = ENTRY_W'(chk_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      cur        <= '0;
      chain_open <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            res_cluster <= '0;
            res_read    <= '0;
            res_status  <= (!chain_open && (kind == KIND_NEXT || kind == KIND_END)) ?
                           STATUS_NO_CHAIN : STATUS_OK;
            ptr         <= FIRST_DATA_ENTRY;
            chk_valid   <= 1'b0;
            skip_q      <= (kind == KIND_NEXT);
            if (kind == KIND_END && chain_open) chain_open <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (found) begin
            cur         <= chk_idx;
            chain_open  <= 1'b1;
            res_cluster <= ENTRY_W'(chk_idx);
          end else if (exhausted) begin
            res_status <= STATUS_NO_FREE;
          end else begin
            chk_valid <= 1'b1;
            chk_idx   <= ptr[AW-1:0];
            ptr       <= ptr + 1'b1;
          end
        end
        ST_READ: res_read <= mem_rdata;
        default: begin
        end
      endcase
    end
  end

  assign res.valid      = (state == ST_FINISH);
  assign res.cluster    = res_cluster;
  assign res.read_value = res_read;
  assign res.status     = res_status;

  `FCA_ASSERT_NXT(a_read_goes_read, clk, rst, accept && kind == KIND_READ, state == ST_READ)
  `FCA_ASSERT_IMP(a_chk_above_first, clk, rst, chk_live, LIMIT_W'(chk_idx) >= FIRST_DATA_ENTRY)
  `FCA_ASSERT_NXT(a_res_holds, clk, rst, res.valid && !res_take, res.valid && $stable(res.status))
  `FCA_ASSERT_NXT(a_open_from_scan, clk, rst, !chain_open && state != ST_SCAN, !chain_open)

endmodule

// ===== bench/tb_fat12_cluster_chain_allocator.sv =====
`timescale 1ns / 100ps
// testbench for fat12_cluster_chain_allocator: directed and random chain traffic
// checked against a table model kept here; scan limit set over the apb port
// depends on fca_pkg and the allocator rtl
module tb_fat12_cluster_chain_allocator;
  import fca_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int NO_ENTRY = -1;
  localparam logic [PADDR_W-1:0] SCAN_LIMIT_ADDR = PADDR_W'(4 * REG_SCAN_LIMIT);

  typedef struct packed {
    logic [ENTRY_W-1:0]  cluster;
    logic [ENTRY_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = KIND_READ;
  logic [ENTRY_W-1:0]  entry_index = '0;
  logic [ENTRY_W-1:0]  entry_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ENTRY_W-1:0]  cluster;
  logic [ENTRY_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // table model
  logic [ENTRY_W-1:0] fat_model [TABLE_ENTRIES_DEF];
  logic [ENTRY_W-1:0] cur_cluster_model = '0;
  bit                 chain_open_model = 1'b0;
  logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;

  alloc_result_t pending_responses[$];
  alloc_result_t last_response;
  alloc_result_t due;

  int unsigned send_gap_pct = 25;
  int unsigned sink_stall_pct = 75;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned no_free_count = 0;
  int unsigned no_chain_count = 0;
  int unsigned cycle_count = 0;

  fat12_cluster_chain_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .entry_index(entry_index), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .cluster(cluster), .read_value(read_value), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic int first_free_entry(input bit skip_current);
    int top;
    top = (limit_model > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : int'(limit_model);
    for (int i = FIRST_DATA_ENTRY; i < top; i++) begin
      if (fat_model[i] != ENTRY_FREE) continue;
      if (skip_current && i == cur_cluster_model) continue;
      return i;
    end
    return NO_ENTRY;
  endfunction

  function automatic alloc_result_t allocator_response(input logic [KIND_W-1:0] k,
                                                       input logic [ENTRY_W-1:0] idx,
                                                       input logic [ENTRY_W-1:0] val);
    alloc_result_t r;
    int found;
    r = '0;
    case (k)
      KIND_START: begin
        found = first_free_entry(1'b0);
        if (found == NO_ENTRY) begin
          r.status = STATUS_NO_FREE;
        end else begin
          cur_cluster_model = ENTRY_W'(found);
          chain_open_model = 1'b1;
          r.cluster = ENTRY_W'(found);
        end
      end
      KIND_NEXT: begin
        if (!chain_open_model) begin
          r.status = STATUS_NO_CHAIN;
        end else begin
          found = first_free_entry(1'b1);
          if (found == NO_ENTRY) begin
            r.status = STATUS_NO_FREE;
          end else begin
            fat_model[cur_cluster_model] = ENTRY_W'(found);
            cur_cluster_model = ENTRY_W'(found);
            r.cluster = ENTRY_W'(found);
          end
        end
      end
      KIND_END: begin
        if (!chain_open_model) begin
          r.status = STATUS_NO_CHAIN;
        end else begin
          fat_model[cur_cluster_model] = END_MARK;
          chain_open_model = 1'b0;
        end
      end
      KIND_WRITE: fat_model[idx] = val;
      KIND_READ: r.read_value = fat_model[idx];
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] k, input logic [ENTRY_W-1:0] idx,
                              input logic [ENTRY_W-1:0] val);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    last_response = allocator_response(k, idx, val);
    pending_responses.push_back(last_response);
    requests_sent++;
  endtask

  task automatic hold_requests();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_scan_limit(input int unsigned lim);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SCAN_LIMIT_ADDR;
    pwdata <= PDATA_W'(lim);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_model = LIMIT_W'(lim);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LIMIT_W-1:0] !== limit_model)
      report_mismatch("scan_limit readback", prdata[LIMIT_W-1:0], limit_model);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_entry_access();
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] val;
    idx = ($urandom_range(1) == 0) ? ENTRY_W'($urandom_range(63)) : ENTRY_W'($urandom());
    val = ($urandom_range(2) == 0) ? ENTRY_FREE : ENTRY_W'($urandom());
    send_request(($urandom_range(1) == 0) ? KIND_WRITE : KIND_READ, idx, val);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_responses.size() == 0) begin
        report_mismatch("result with no request pending", status, 0);
      end else begin
        due = pending_responses.pop_front();
        if (cluster !== due.cluster) report_mismatch("cluster", cluster, due.cluster);
        if (read_value !== due.read_value)
          report_mismatch("read_value", read_value, due.read_value);
        if (status !== due.status) report_mismatch("status", status, due.status);
        if (due.status == STATUS_NO_FREE) no_free_count++;
        if (due.status == STATUS_NO_CHAIN) no_chain_count++;
      end
    end
  end

  // empty table, no chain open, unused kinds
  task automatic test_idle_table();
    send_request(KIND_READ, 12'h000, 12'hFFF);
    send_request(KIND_READ, 12'hFFF, 12'h000);
    send_request(KIND_NEXT, 12'hFFF, 12'hFFF);
    send_request(KIND_END, 12'h000, 12'h000);
    send_request(KIND_W'(5), 12'h002, 12'h123);
    send_request(KIND_W'(7), 12'hABC, 12'hFFF);
  endtask

  task automatic test_chain_linking();
    send_request(KIND_START, 12'h000, 12'h000);
    send_request(KIND_NEXT, 12'h000, 12'h000);
    send_request(KIND_NEXT, 12'h000, 12'h000);
    send_request(KIND_END, 12'h000, 12'h000);
    send_request(KIND_READ, 12'h002, 12'h000);
    send_request(KIND_READ, 12'h004, 12'h000);
    // restart while open lands on the same still-free cluster
    send_request(KIND_START, 12'h000, 12'h000);
    send_request(KIND_START, 12'h000, 12'h000);
    send_request(KIND_NEXT, 12'h000, 12'h000);
    send_request(KIND_END, 12'h000, 12'h000);
    send_request(KIND_WRITE, 12'hFFF, 12'hFFF);
    send_request(KIND_WRITE, 12'h000, 12'hABC);
    send_request(KIND_READ, 12'hFFF, 12'h000);
  endtask

  task automatic test_scan_limit_extremes();
    hold_requests();
    write_scan_limit(3);
    send_request(KIND_WRITE, 12'h002, ENTRY_FREE);
    send_request(KIND_START, 12'h000, 12'h000);
    send_request(KIND_NEXT, 12'h000, 12'h000);
    send_request(KIND_END, 12'h000, 12'h000);
    send_request(KIND_START, 12'h000, 12'h000);
    hold_requests();
    write_scan_limit(TABLE_ENTRIES_DEF);
    send_request(KIND_START, 12'h000, 12'h000);
    send_request(KIND_END, 12'h000, 12'h000);
  endtask

  task automatic test_random_chains(input int unsigned n_items, input int unsigned lim,
                                    input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned start_count;
    logic [ENTRY_W-1:0] chain_members[$];
    hold_requests();
    write_scan_limit(lim);
    send_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    start_count = requests_sent;
    while (requests_sent - start_count < n_items) begin
      if ($urandom_range(99) < 70) begin
        chain_members.delete();
        send_request(KIND_START, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
        if (last_response.status == STATUS_OK) chain_members.push_back(last_response.cluster);
        repeat ($urandom_range(6)) begin
          if ($urandom_range(3) == 0) send_entry_access();
          send_request(KIND_NEXT, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
          if (last_response.status == STATUS_OK) chain_members.push_back(last_response.cluster);
        end
        if ($urandom_range(9) != 0)
          send_request(KIND_END, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
        repeat ($urandom_range(3)) begin
          if (chain_members.size() != 0)
            send_request(KIND_READ, chain_members[$urandom_range(chain_members.size() - 1)],
                         ENTRY_W'($urandom()));
        end
      end else if ($urandom_range(1) == 0) begin
        send_entry_access();
      end else begin
        send_request(KIND_W'($urandom_range(7)), ENTRY_W'($urandom()), ENTRY_W'($urandom()));
      end
    end
  endtask

  initial begin
    foreach (fat_model[i]) fat_model[i] = ENTRY_FREE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_table();
    test_chain_linking();
    test_scan_limit_extremes();
    test_random_chains(36, $urandom_range(16, 64), 25, 75);
    test_random_chains(36, LIMIT_RESET, 75, 25);
    test_random_chains(34, TABLE_ENTRIES_DEF, 0, 0);
    hold_requests();
    repeat (TABLE_ENTRIES_DEF + 16) @(posedge clk);
    $display("checked %0d results for %0d requests over scan limits from 3 to %0d",
             results_checked, requests_sent, TABLE_ENTRIES_DEF);
    $display("failed searches: %0d, requests with no chain open: %0d",
             no_free_count, no_chain_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fca_pkg.sv
design/fca_table.sv
design/fca_ctrl.sv
design/fat12_cluster_chain_allocator.sv
bench/tb_fat12_cluster_chain_allocator.sv
